>>> rtl/core/npq_pkg.sv
// Shared types, constants and helper functions for the nearest palette quantizer.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package npq_pkg;

  localparam int PAL_ENTRIES  = 16;  // entries compared, 2..16
  localparam int NUM_SLOTS    = 16;  // slots held in the palette words
  localparam int PAL_WORDS    = 6;
  localparam int WORD_W       = 64;
  localparam int ENTRY_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int IDX_W        = 4;
  localparam int SQ_W         = 2 * CHAN_W;
  localparam int DIST_W       = SQ_W + 2;
  localparam int CFG_IDX_W    = 3;
  localparam int PAL_BITS     = PAL_WORDS * WORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PAL_LAST = CFG_IDX_W'(PAL_WORDS - 1);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = CFG_IDX_W'(6);
  localparam logic [CHAN_W-1:0]    ALPHA_RESET  = CHAN_W'(128);

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [DIST_W-1:0] dist_t;

  // configuration state handed from the register file to the datapath
  typedef struct packed {
    logic [PAL_BITS-1:0] palette;
    chan_t               alpha_cutoff;
  } cfg_t;

  // one candidate in the minimum search
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
    dist_t            metric;
  } cand_t;

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    return (a > b) ? chan_t'(a - b) : chan_t'(b - a);
  endfunction

  // a holds the lower index, so b wins only when strictly nearer
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.ok && (!a.ok || b.metric < a.metric)) ? b : a;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/npq_cfg.sv
// Configuration register file: six palette words and the alpha cutoff.
// Depends on npq_pkg.
`default_nettype none

module npq_cfg
  import npq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output cfg_t                      cfg
);

  logic [PAL_WORDS-1:0][WORD_W-1:0] palette_word;
  chan_t                            alpha_cutoff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_word <= '0;
      alpha_cutoff <= ALPHA_RESET;
    end else if (cfg_valid) begin
      // drop writes to unknown indexes
      if (cfg_index <= CFG_PAL_LAST) begin
        palette_word[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_ALPHA) begin
        alpha_cutoff <= cfg_data[CHAN_W-1:0];
      end
    end
  end

  assign cfg.palette      = palette_word;
  assign cfg.alpha_cutoff = alpha_cutoff;

endmodule

`default_nettype wire

>>> rtl/core/npq_dist.sv
// Distance pipeline: absolute differences, squares, and per-entry sums in three stages.
// Depends on npq_pkg; palette and cutoff come from npq_cfg.
`default_nettype none

module npq_dist
  import npq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire chan_t red,
  input  wire chan_t green,
  input  wire chan_t blue,
  input  wire chan_t alpha,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_transparent,
  output dist_t [NUM_SLOTS-1:0] out_dist
);

  logic v1, v2, v3;
  logic en1, en2, en3;
  logic tr1, tr2, tr3;

  logic [NUM_SLOTS-1:0][CHAN_W-1:0] dr, dg, db;
  logic [NUM_SLOTS-1:0][SQ_W-1:0]   sqr, sqg, sqb;
  dist_t [NUM_SLOTS-1:0]            dsum;

  // a stage advances when empty or when the next one takes its word
  assign en3      = ~v3 | out_ready;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      tr1 <= alpha < cfg.alpha_cutoff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        dr[i] <= abs_diff(red,   cfg.palette[ENTRY_W*i + 2*CHAN_W +: CHAN_W]);
        dg[i] <= abs_diff(green, cfg.palette[ENTRY_W*i + CHAN_W   +: CHAN_W]);
        db[i] <= abs_diff(blue,  cfg.palette[ENTRY_W*i            +: CHAN_W]);
      end
    end
    if (en2) begin
      tr2 <= tr1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        sqr[i] <= SQ_W'(dr[i]) * SQ_W'(dr[i]);
        sqg[i] <= SQ_W'(dg[i]) * SQ_W'(dg[i]);
        sqb[i] <= SQ_W'(db[i]) * SQ_W'(db[i]);
      end
    end
    if (en3) begin
      tr3 <= tr2;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        dsum[i] <= DIST_W'(sqr[i]) + DIST_W'(sqg[i]) + DIST_W'(sqb[i]);
      end
    end
  end

  assign out_valid       = v3;
  assign out_transparent = tr3;
  assign out_dist        = dsum;

endmodule

`default_nettype wire

>>> rtl/core/npq_argmin.sv
// Registered comparison tree: 16 distances to 4 candidates, then to the winning index.
// Depends on npq_pkg; distances come from npq_dist.
`default_nettype none

module npq_argmin
  import npq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_transparent,
  input  wire dist_t [NUM_SLOTS-1:0] in_dist,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IDX_W-1:0]           palette_index,
  output logic                       was_transparent
);

  localparam int L1_N = NUM_SLOTS / 2;
  localparam int L2_N = NUM_SLOTS / 4;

  cand_t [NUM_SLOTS-1:0] leaf;
  cand_t [L1_N-1:0]      lvl1;
  cand_t [L2_N-1:0]      lvl2;
  cand_t [L2_N-1:0]      c4;
  cand_t [1:0]           lvl3;
  cand_t                 best;

  logic v4, v5;
  logic en4, en5;
  logic tr4;

  assign en5      = ~v5 | out_ready;
  assign en4      = ~v4 | en5;
  assign in_ready = en4;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      // slots past the configured count never win
      leaf[i].ok     = i < PAL_ENTRIES;
      leaf[i].idx    = IDX_W'(i);
      leaf[i].metric = in_dist[i];
    end
    for (int j = 0; j < L1_N; j++) lvl1[j] = pick(leaf[2*j], leaf[2*j+1]);
    for (int k = 0; k < L2_N; k++) lvl2[k] = pick(lvl1[2*k], lvl1[2*k+1]);
    lvl3[0] = pick(c4[0], c4[1]);
    lvl3[1] = pick(c4[2], c4[3]);
    best    = pick(lvl3[0], lvl3[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      tr4 <= in_transparent;
      c4  <= lvl2;
    end
    if (en5) begin
      was_transparent <= tr4;
      palette_index   <= tr4 ? '0 : best.idx;
    end
  end

  assign out_valid = v5;

endmodule

`default_nettype wire

>>> rtl/core/nearest_palette_quantizer_core.sv
// Nearest palette quantizer: RGBA pixel in, 4-bit palette index out.
// Five register stages (diff, square, sum, two tree stages); the first is loaded
// at the accepting edge.
// Throughput: one pixel per cycle; each stage holds under back-pressure and bubbles close up.
// Reset: synchronous, clears all stage valid bits, palette words to zero, cutoff to 128.
// Depends on npq_pkg, npq_cfg, npq_dist and npq_argmin.
`default_nettype none

module nearest_palette_quantizer_core
  import npq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CHAN_W-1:0]    red,
  input  wire logic [CHAN_W-1:0]    green,
  input  wire logic [CHAN_W-1:0]    blue,
  input  wire logic [CHAN_W-1:0]    alpha,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [IDX_W-1:0]          palette_index,
  output logic                      was_transparent,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  cfg_t                  cfg;
  logic                  d_valid;
  logic                  d_ready;
  logic                  d_transparent;
  dist_t [NUM_SLOTS-1:0] d_dist;

  npq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  npq_dist u_dist (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .alpha           (alpha),
    .out_valid       (d_valid),
    .out_ready       (d_ready),
    .out_transparent (d_transparent),
    .out_dist        (d_dist)
  );

  npq_argmin u_argmin (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (d_valid),
    .in_ready        (d_ready),
    .in_transparent  (d_transparent),
    .in_dist         (d_dist),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .palette_index   (palette_index),
    .was_transparent (was_transparent)
  );

endmodule

`default_nettype wire
